### sv/rgbhsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV pixel core.
// Depends on nothing; every other file imports it.
package rgbhsv_pkg;

   localparam int CHAN_W   = 8;
   localparam int QUO_W    = 16;
   localparam int NUM_W    = CHAN_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;
   // front stage + one cell per quotient bit + output register
   localparam int PIPE_LATENCY = DIV_STEPS + 2;

   // hue bases in half-degrees, scaled by 256
   localparam logic [QUO_W-1:0] HUE_BASE_RED   = QUO_W'(0);
   localparam logic [QUO_W-1:0] HUE_BASE_WRAP  = QUO_W'(180 * 256);
   localparam logic [QUO_W-1:0] HUE_BASE_GREEN = QUO_W'(60 * 256);
   localparam logic [QUO_W-1:0] HUE_BASE_BLUE  = QUO_W'(120 * 256);
   // 60 degrees of hue per unit of diff/delta, halved, scaled by 256
   localparam logic [QUO_W-1:0] HUE_SLOPE      = QUO_W'(30 * 256);
   localparam logic [QUO_W-1:0] HUE_LIMIT      = QUO_W'(180 * 256);

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [QUO_W-1:0]  hue_half_q8;
      logic [QUO_W-1:0]  saturation_q8;
      logic [CHAN_W-1:0] value_out;
   } rsp_word_type;

   // one restoring divider: remainder in the top bits, numerator bits shift
   // out of the low part while quotient bits shift in
   typedef struct packed {
      logic [NUM_W-1:0]  work;
      logic [CHAN_W-1:0] divisor;
   } lane_type;

   typedef struct packed {
      logic              valid;
      lane_type          hue;
      lane_type          sat;
      logic [CHAN_W-1:0] value;
      logic              gray;
      logic              black;
   } cell_type;

   function automatic lane_type div_step(lane_type lane);
      logic [CHAN_W:0]   trial;
      logic              ge;
      logic [CHAN_W-1:0] rem;
      lane_type          nxt;
      trial = {lane.work[NUM_W-1:QUO_W], lane.work[QUO_W-1]};
      ge    = (trial >= {1'b0, lane.divisor});
      rem   = ge ? CHAN_W'(trial - {1'b0, lane.divisor}) : trial[CHAN_W-1:0];
      nxt.divisor = lane.divisor;
      nxt.work    = {rem, lane.work[QUO_W-2:0], ge};
      return nxt;
   endfunction

endpackage

### sv/rgbhsv_front.sv
// Front stage: max/min, branch select and divider numerators, registered.
// Depends on rgbhsv_pkg.
module rgbhsv_front
   import rgbhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type pixel,
   output cell_type     cell_out
);

   logic [CHAN_W-1:0] r, g, b, mx, mn, delta, abs_diff;
   logic              red_max, green_max, sub;
   logic [QUO_W-1:0]  base;
   logic [NUM_W-1:0]  base_term, slope_term, hue_num, sat_num;
   cell_type          cell_in, cell_ff;

   always_comb begin
      r = pixel.red_in;
      g = pixel.green_in;
      b = pixel.blue_in;
      red_max   = (r >= g) && (r >= b);
      green_max = !red_max && (g >= b);
      mx = red_max ? r : (green_max ? g : b);
      mn = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
      delta = mx - mn;

      if (red_max) begin
         sub      = (g < b);
         base     = sub ? HUE_BASE_WRAP : HUE_BASE_RED;
         abs_diff = sub ? (b - g) : (g - b);
      end else if (green_max) begin
         sub      = (b < r);
         base     = HUE_BASE_GREEN;
         abs_diff = sub ? (r - b) : (b - r);
      end else begin
         sub      = (r < g);
         base     = HUE_BASE_BLUE;
         abs_diff = sub ? (g - r) : (r - g);
      end

      base_term  = NUM_W'(base) * NUM_W'(delta);
      slope_term = NUM_W'(HUE_SLOPE) * NUM_W'(abs_diff);
      hue_num    = sub ? (base_term - slope_term) : (base_term + slope_term);
      // 65280 * delta
      sat_num    = {delta, QUO_W'(0)} - {CHAN_W'(0), delta, CHAN_W'(0)};

      cell_in.valid       = accept;
      cell_in.hue.work    = hue_num;
      cell_in.hue.divisor = delta;
      cell_in.sat.work    = sat_num;
      cell_in.sat.divisor = mx;
      cell_in.value       = mx;
      cell_in.gray        = (delta == '0);
      cell_in.black       = (mx == '0);
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign cell_out = cell_ff;

endmodule

### sv/rgbhsv_div_cell.sv
// One divider cell: retires one quotient bit of both the hue and the
// saturation division and hands the word on. Depends on rgbhsv_pkg.
module rgbhsv_div_cell
   import rgbhsv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_in,
   output cell_type cell_out
);

   cell_type cell_ff;

   always_ff @(posedge clock) begin
      cell_ff.valid <= cell_in.valid;
      cell_ff.hue   <= div_step(cell_in.hue);
      cell_ff.sat   <= div_step(cell_in.sat);
      cell_ff.value <= cell_in.value;
      cell_ff.gray  <= cell_in.gray;
      cell_ff.black <= cell_in.black;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign cell_out = cell_ff;

endmodule

### sv/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel converter, half-hue convention, Q8.8 hue and saturation.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_cell.
//
// Usage:
//   Input: drive req_word (red, green, blue) and raise start. A word is
//   taken at each rising edge with start high and busy low. busy is high
//   only while reset is held; otherwise a word can enter on every cycle.
//   Output: each result appears on rsp_word for one cycle with strobe high,
//   after passing the front, divider cell and output registers, in order.
//   The receiver cannot stall; results must be captured when strobe is high.
// Throughput: one pixel per clock while reset is low.
// Pipeline: one front stage (max/min, numerators), a row of 16 divider
//   cells, each resolving one quotient bit of both divisions, and one
//   output register; gray pixels get zero hue, black ones zero saturation.
// Reset: synchronous; clears all valid bits, so no strobe follows reset
//   until new words are taken.
module rgb_to_hsv_pixel_core
   import rgbhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         strobe,
   output rsp_word_type rsp_word
);

   cell_type     chain [DIV_STEPS+1];
   logic         strobe_ff, strobe_in;
   rsp_word_type rsp_ff, rsp_in;
   cell_type     last;

   assign busy = reset;

   rgbhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .pixel    (req_word),
      .cell_out (chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rgbhsv_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   always_comb begin
      last      = chain[DIV_STEPS];
      strobe_in = last.valid;
      rsp_in.hue_half_q8   = last.gray  ? '0 : last.hue.work[QUO_W-1:0];
      rsp_in.saturation_q8 = last.black ? '0 : last.sat.work[QUO_W-1:0];
      rsp_in.value_out     = last.value;
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      strobe_ff <= strobe_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end
   end

   assign strobe   = strobe_ff;
   assign rsp_word = rsp_ff;

endmodule

### sv/rgbhsv_checker.sv
// Port-level checks for rgb_to_hsv_pixel_core, attached by bind.
// Depends on rgbhsv_pkg.
module rgbhsv_checker
   import rgbhsv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         strobe,
   input rsp_word_type rsp_word
);

   // every word taken comes back with a strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY strobe)
      else $error("missing result word");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result word without a request");

   a_value: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_word.value_out >= $past(req_word.red_in, PIPE_LATENCY))
              && (rsp_word.value_out >= $past(req_word.green_in, PIPE_LATENCY))
              && (rsp_word.value_out >= $past(req_word.blue_in, PIPE_LATENCY)))
      else $error("value is not the channel maximum");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (strobe && rsp_word.value_out == '0) |->
         (rsp_word.hue_half_q8 == '0) && (rsp_word.saturation_q8 == '0))
      else $error("black pixel with nonzero hue or saturation");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_word.hue_half_q8 < HUE_LIMIT))
      else $error("hue out of range");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_checker u_rgbhsv_checker (.*);
